@@ hw/rtl/pcxrle_pkg.sv @@
// ----------------------------------------------------------------------------
// PCX RLE palette decoder package
// Shared constants, command codes, payload structs and internal bus types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcxrle_pkg;

  // Row and palette geometry.
  localparam int MAX_ROW_WIDTH = 4096;
  localparam int PALETTE_SIZE  = 256;
  localparam int COL_W         = $clog2(MAX_ROW_WIDTH + 1);
  localparam int PAL_AW        = $clog2(PALETTE_SIZE);
  localparam int ENTRY_W       = 32;
  localparam int WIDTH_REG_W   = 13;
  localparam int RUN_W         = 6;

  localparam logic [WIDTH_REG_W-1:0] ROW_WIDTH_RESET = WIDTH_REG_W'(640);
  localparam logic [7:0]             RUN_TAG_MASK    = 8'hC0;
  localparam logic [RUN_W-1:0]       RUN_ONE         = RUN_W'(1);
  localparam logic [ENTRY_W-1:0]     ENTRY_CLEAR     = 32'h0000_0000;

  // Command codes carried in the command field.
  localparam logic [1:0] CMD_PALETTE   = 2'd0;
  localparam logic [1:0] CMD_DATA      = 2'd1;
  localparam logic [1:0] CMD_ROW_START = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [7:0] entry_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
    logic [7:0] entry_flags;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic [11:0] pixel_x;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic        write_enable;
    logic        row_done;
    logic        last_of_item;
  } out_item_t;

  // Palette write request.
  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [ENTRY_W-1:0] data;
  } pal_wr_t;

  // Palette read request.
  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
  } pal_rd_t;

  // Decoder sequencer states.
  typedef enum logic {
    S_IDLE,
    S_EMIT
  } dec_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/pcxrle_palette_ram.sv @@
// ----------------------------------------------------------------------------
// PCX RLE palette RAM
// 256 x 32 synchronous palette memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_palette_ram
  import pcxrle_pkg::*;
(
  input  wire logic               clk,
  input  wire pal_wr_t            wr,
  input  wire pal_rd_t            rd,
  output logic [ENTRY_W-1:0]      rd_data
);

  logic [ENTRY_W-1:0] mem [PALETTE_SIZE];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pcxrle_decoder_core.sv @@
// ----------------------------------------------------------------------------
// PCX RLE decoder core
// Parses run headers and literals, drives the palette RAM and emits pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_decoder_core
  import pcxrle_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [COL_W-1:0]   width,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire in_item_t           item,
  output logic                    pixel_valid,
  input  wire logic               pixel_ready,
  output out_item_t               pixel,
  output pal_wr_t                 pal_wr,
  output pal_rd_t                 pal_rd,
  input  wire logic [ENTRY_W-1:0] pal_data
);

  dec_state_t       state, state_next;
  logic [COL_W-1:0] col, col_next;
  logic             run_pending, run_pending_next;
  logic [RUN_W-1:0] run_length, run_length_next;
  logic             row_complete, row_complete_next;
  logic [RUN_W-1:0] count, count_next;
  logic             literal, literal_next;
  logic             out_valid_next;
  out_item_t        pixel_next;

  logic             accept;
  logic             done_now;
  logic [COL_W-1:0] col_inc;
  logic             we;
  logic             last_px;
  logic             load;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign done_now   = row_complete || (col >= width);
  assign col_inc    = col + COL_W'(1);
  assign we         = literal || (pal_data != ENTRY_CLEAR);
  assign last_px    = (count == RUN_ONE) || (col_inc >= width);
  assign load       = (state == S_EMIT) && (!pixel_valid || pixel_ready);

  // Palette writes go straight to the RAM on acceptance.
  always_comb begin
    pal_wr.en   = accept && (item.command == CMD_PALETTE);
    pal_wr.addr = item.entry_index;
    pal_wr.data = {item.entry_flags, item.entry_blue, item.entry_green, item.entry_red};
  end

  // Sequencer next state, palette reads and output register loads.
  always_comb begin
    state_next        = state;
    col_next          = col;
    run_pending_next  = run_pending;
    run_length_next   = run_length;
    row_complete_next = row_complete;
    count_next        = count;
    literal_next      = literal;
    out_valid_next    = pixel_valid && !pixel_ready;
    pixel_next        = pixel;
    pal_rd.en         = 1'b0;
    pal_rd.addr       = item.data_byte;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.command)
            CMD_ROW_START: begin
              col_next          = '0;
              run_pending_next  = 1'b0;
              run_length_next   = '0;
              row_complete_next = 1'b0;
            end
            CMD_DATA: begin
              if (done_now) begin
                row_complete_next = 1'b1;
              end else if (run_pending) begin
                run_pending_next = 1'b0;
                run_length_next  = '0;
                if (run_length != '0) begin
                  pal_rd.en    = 1'b1;
                  count_next   = run_length;
                  literal_next = 1'b0;
                  state_next   = S_EMIT;
                end
              end else if ((item.data_byte & RUN_TAG_MASK) == RUN_TAG_MASK) begin
                run_pending_next = 1'b1;
                run_length_next  = item.data_byte[RUN_W-1:0];
              end else begin
                pal_rd.en    = 1'b1;
                count_next   = RUN_ONE;
                literal_next = 1'b1;
                state_next   = S_EMIT;
              end
            end
            default: begin
              // Palette writes are handled above; other codes are ignored.
            end
          endcase
        end
      end
      S_EMIT: begin
        if (load) begin
          out_valid_next           = 1'b1;
          pixel_next.pixel_x       = col[11:0];
          pixel_next.pixel_red     = we ? pal_data[7:0]   : 8'd0;
          pixel_next.pixel_green   = we ? pal_data[15:8]  : 8'd0;
          pixel_next.pixel_blue    = we ? pal_data[23:16] : 8'd0;
          pixel_next.write_enable  = we;
          pixel_next.row_done      = (col_inc == width);
          pixel_next.last_of_item  = last_px;
          col_next                 = col_inc;
          count_next               = count - RUN_ONE;
          if (last_px) begin
            state_next = S_IDLE;
            if (col_inc >= width) begin
              row_complete_next = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      col          <= '0;
      run_pending  <= 1'b0;
      run_length   <= '0;
      row_complete <= 1'b0;
      count        <= '0;
      literal      <= 1'b0;
      pixel_valid  <= 1'b0;
    end else begin
      state        <= state_next;
      col          <= col_next;
      run_pending  <= run_pending_next;
      run_length   <= run_length_next;
      row_complete <= row_complete_next;
      count        <= count_next;
      literal      <= literal_next;
      pixel_valid  <= out_valid_next;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    pixel <= pixel_next;
  end

endmodule

`default_nettype wire

@@ hw/rtl/pcx_rle_palette_decoder.sv @@
// ----------------------------------------------------------------------------
// PCX RLE palette decoder, top level
// Decodes a PCX run-length encoded row of palette indices into RGB pixels.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  item      in         item_valid/item_ready   in_item_t
//  pixel     out        pixel_valid/pixel_ready out_item_t
//  cfg       in         cfg_valid/cfg_ready     row_width, 13 bits
//
// Palette writes, row starts, run headers and ignored bytes do not stall.
// A literal or run index reads the palette RAM on acceptance, then emits its
// pixels (1 to 63) one per cycle, paced by pixel_ready.
// Reset clears the row position and run state; the palette is not cleared.
// A new item is taken while the last pixel of the previous one still waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcx_rle_palette_decoder
  import pcxrle_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire in_item_t               item,
  output logic                        pixel_valid,
  input  wire logic                   pixel_ready,
  output out_item_t                   pixel,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [WIDTH_REG_W-1:0] cfg_data
);

  logic [WIDTH_REG_W-1:0] row_width;
  logic [COL_W-1:0]       width;
  pal_wr_t                pal_wr;
  pal_rd_t                pal_rd;
  logic [ENTRY_W-1:0]     pal_data;

  assign cfg_ready = 1'b1;

  // Row width register.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      row_width <= cfg_data;
    end
  end

  // Effective width saturates at the largest supported row.
  always_comb begin
    if (32'(row_width) > MAX_ROW_WIDTH) begin
      width = COL_W'(MAX_ROW_WIDTH);
    end else begin
      width = COL_W'(row_width);
    end
  end

  pcxrle_palette_ram u_ram (
    .clk     (clk),
    .wr      (pal_wr),
    .rd      (pal_rd),
    .rd_data (pal_data)
  );

  pcxrle_decoder_core u_core (
    .clk         (clk),
    .rst         (rst),
    .width       (width),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .pal_wr      (pal_wr),
    .pal_rd      (pal_rd),
    .pal_data    (pal_data)
  );

endmodule

`default_nettype wire

@@ hw/rtl/pcxrle_checker.sv @@
// ----------------------------------------------------------------------------
// PCX RLE decoder port checker
// Concurrent assertions on the top-level ports, bound to the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_checker
  import pcxrle_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   item_valid,
  input wire logic                   item_ready,
  input wire in_item_t               item,
  input wire logic                   pixel_valid,
  input wire logic                   pixel_ready,
  input wire out_item_t              pixel,
  input wire logic                   cfg_valid,
  input wire logic                   cfg_ready,
  input wire logic [WIDTH_REG_W-1:0] cfg_data
);

  // A stalled pixel transaction holds its payload.
  a_pixel_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel))
    else $error("pixel payload changed while stalled");

  // A palette write or row start never holds off the next transaction.
  a_short_cmd: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready &&
    (item.command == CMD_PALETTE || item.command == CMD_ROW_START)
    |=> item_ready)
    else $error("single-cycle command stalled the input");

  // The pixel that ends the row also ends its transaction.
  a_row_done_last: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel.row_done |-> pixel.last_of_item)
    else $error("row_done without last_of_item");

  // Skipped pixels carry a black color.
  a_skip_black: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel.write_enable |->
    pixel.pixel_red == 8'd0 && pixel.pixel_green == 8'd0 && pixel.pixel_blue == 8'd0)
    else $error("skipped pixel has nonzero color");

  // The configuration channel never stalls.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind pcx_rle_palette_decoder pcxrle_checker u_checker (.*);

`default_nettype wire

@@ sim/pcx_decode_checker.sv @@
// ----------------------------------------------------------------------------
// PCX RLE decoder pixel checker
// Watches the item, pixel and configuration channels of the decoder. It keeps
// its own copy of the palette, row position and run state, works out the
// pixels that each accepted item should produce, and compares every accepted
// pixel field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcx_decode_checker
  import pcxrle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   item_ready,
  input  in_item_t               item,
  input  logic                   pixel_valid,
  input  logic                   pixel_ready,
  input  out_item_t              pixel,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [WIDTH_REG_W-1:0] cfg_data,
  output int                     fails,
  output int                     pending
);

  // Predicted decoder state.
  logic [ENTRY_W-1:0]     palette_copy [PALETTE_SIZE];
  logic [WIDTH_REG_W-1:0] width_reg;
  logic [12:0]            col_pos;
  logic                   run_armed;
  logic [RUN_W-1:0]       run_count;
  logic                   row_full;
  int                     active_width;

  // Pixels predicted but not yet seen on the output channel.
  out_item_t pixels_due [$];

  int        mismatch_total = 0;
  int        produced;
  int        k;
  out_item_t seen;
  out_item_t wanted;
  logic [ENTRY_W-1:0] entry_word;

  // Print one line per mismatch and count it.
  task automatic log_mismatch(input string msg);
    mismatch_total++;
    $display("%0t ns: pixel mismatch: %s", $time, msg);
  endtask

  // Queue one predicted pixel at the current position and advance it.
  function automatic void queue_pixel(input logic [ENTRY_W-1:0] entry, input bit we);
    out_item_t px;
    px.pixel_x      = col_pos[11:0];
    px.pixel_red    = we ? entry[7:0]   : 8'h00;
    px.pixel_green  = we ? entry[15:8]  : 8'h00;
    px.pixel_blue   = we ? entry[23:16] : 8'h00;
    px.write_enable = we;
    px.row_done     = (int'(col_pos) + 1 == active_width);
    px.last_of_item = 1'b0;
    pixels_due.push_back(px);
    col_pos = col_pos + 13'd1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg = ROW_WIDTH_RESET;
      col_pos   = '0;
      run_armed = 1'b0;
      run_count = '0;
      row_full  = 1'b0;
      pixels_due.delete();
    end else begin
      // Compare an accepted pixel transaction with the oldest prediction.
      if (pixel_valid && pixel_ready) begin
        seen = pixel;
        if (pixels_due.size() == 0) begin
          log_mismatch($sformatf("unexpected pixel at x=%0d", seen.pixel_x));
        end else begin
          wanted = pixels_due.pop_front();
          if (seen.pixel_x !== wanted.pixel_x)
            log_mismatch($sformatf("pixel_x got %0d want %0d",
                                   seen.pixel_x, wanted.pixel_x));
          if (seen.pixel_red !== wanted.pixel_red)
            log_mismatch($sformatf("x=%0d pixel_red got %h want %h",
                                   wanted.pixel_x, seen.pixel_red, wanted.pixel_red));
          if (seen.pixel_green !== wanted.pixel_green)
            log_mismatch($sformatf("x=%0d pixel_green got %h want %h",
                                   wanted.pixel_x, seen.pixel_green, wanted.pixel_green));
          if (seen.pixel_blue !== wanted.pixel_blue)
            log_mismatch($sformatf("x=%0d pixel_blue got %h want %h",
                                   wanted.pixel_x, seen.pixel_blue, wanted.pixel_blue));
          if (seen.write_enable !== wanted.write_enable)
            log_mismatch($sformatf("x=%0d write_enable got %b want %b",
                                   wanted.pixel_x, seen.write_enable, wanted.write_enable));
          if (seen.row_done !== wanted.row_done)
            log_mismatch($sformatf("x=%0d row_done got %b want %b",
                                   wanted.pixel_x, seen.row_done, wanted.row_done));
          if (seen.last_of_item !== wanted.last_of_item)
            log_mismatch($sformatf("x=%0d last_of_item got %b want %b",
                                   wanted.pixel_x, seen.last_of_item, wanted.last_of_item));
        end
      end

      // Row width register write.
      if (cfg_valid && cfg_ready) begin
        width_reg = cfg_data;
      end

      // Predict the pixels of an accepted item transaction.
      if (item_valid && item_ready) begin
        active_width = (width_reg > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : int'(width_reg);
        case (item.command)
          CMD_PALETTE: begin
            palette_copy[item.entry_index] = {item.entry_flags, item.entry_blue,
                                              item.entry_green, item.entry_red};
          end
          CMD_ROW_START: begin
            col_pos   = '0;
            run_armed = 1'b0;
            run_count = '0;
            row_full  = 1'b0;
          end
          CMD_DATA: begin
            if (col_pos >= active_width) row_full = 1'b1;
            if (!row_full) begin
              produced = pixels_due.size();
              if (run_armed) begin
                // The run index: expand, clipped at the row width.
                entry_word = palette_copy[item.data_byte];
                for (k = 0; k < run_count && col_pos < active_width; k++) begin
                  queue_pixel(entry_word, entry_word != ENTRY_CLEAR);
                end
                run_armed = 1'b0;
                run_count = '0;
              end else if ((item.data_byte & RUN_TAG_MASK) == RUN_TAG_MASK) begin
                run_armed = 1'b1;
                run_count = item.data_byte[RUN_W-1:0];
              end else begin
                // Literals write even when the entry is all zero.
                queue_pixel(palette_copy[item.data_byte], 1'b1);
              end
              if (col_pos >= active_width) row_full = 1'b1;
              if (pixels_due.size() > produced) begin
                wanted = pixels_due.pop_back();
                wanted.last_of_item = 1'b1;
                pixels_due.push_back(wanted);
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
    pending <= pixels_due.size();
    fails   <= mismatch_total;
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// PCX RLE palette decoder testbench
// Loads palette entries and feeds encoded rows to the decoder under several
// row widths: a directed pass over literals, runs, transparent and zero-count
// runs, clipping and ignored bytes, then a row of runs under a long output
// stall, then random rows with random idle gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pcxrle_pkg::*;

  // Command code the decoder does not use; it must be ignored.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   item_valid  = 1'b0;
  logic                   item_ready;
  in_item_t               item        = '0;
  logic                   pixel_valid;
  logic                   pixel_ready = 1'b0;
  out_item_t              pixel;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [WIDTH_REG_W-1:0] cfg_data    = '0;

  int fails;
  int pending;

  // Pacing controls shared with the pixel sink.
  bit send_quiet    = 1'b0;
  bit sink_quiet    = 1'b0;
  int hold_requests = 0;

  // Palette slots loaded so far; only loaded slots are ever sent as data.
  bit loaded [PALETTE_SIZE];
  int items_sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pcx_rle_palette_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  pcx_decode_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fails       (fails),
    .pending     (pending)
  );

  // Build an item with random filler in the fields the command ignores.
  function automatic in_item_t make_item(input logic [1:0] cmd, input logic [7:0] data);
    in_item_t it;
    it.command     = cmd;
    it.data_byte   = data;
    it.entry_index = 8'($urandom_range(0, 255));
    it.entry_red   = 8'($urandom_range(0, 255));
    it.entry_green = 8'($urandom_range(0, 255));
    it.entry_blue  = 8'($urandom_range(0, 255));
    it.entry_flags = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // A random palette word; a quarter of them are all zero (transparent).
  function automatic logic [ENTRY_W-1:0] fresh_entry();
    return ($urandom_range(0, 3) == 0) ? ENTRY_CLEAR : ENTRY_W'($urandom);
  endfunction

  // Offer one item transaction after a random gap and wait for acceptance.
  // Valid stays high between back-to-back items.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_entry(input logic [7:0] slot, input logic [ENTRY_W-1:0] word);
    in_item_t it;
    it             = make_item(CMD_PALETTE, 8'($urandom_range(0, 255)));
    it.entry_index = slot;
    it.entry_red   = word[7:0];
    it.entry_green = word[15:8];
    it.entry_blue  = word[23:16];
    it.entry_flags = word[31:24];
    send_item(it);
    loaded[slot] = 1'b1;
  endtask

  // Send a data byte, loading its palette slot first if it is still empty,
  // since the byte may be a literal or run index that reads that slot.
  task automatic send_byte(input logic [7:0] b);
    if (!loaded[b]) load_entry(b, fresh_entry());
    send_item(make_item(CMD_DATA, b));
  endtask

  task automatic start_row();
    send_item(make_item(CMD_ROW_START, 8'($urandom_range(0, 255))));
  endtask

  // Wait until every predicted pixel has arrived, then let items that
  // produce nothing settle.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_width(input int w);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= WIDTH_REG_W'(w);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One row: mostly literals and well-formed runs, some noise.
  task automatic random_row(input int tokens);
    int sel;
    start_row();
    repeat (tokens) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send_byte(8'($urandom_range(0, 191)));
      end else if (sel < 85) begin
        send_byte(RUN_TAG_MASK | 8'($urandom_range(0, 63)));
        send_byte(8'($urandom_range(0, 255)));
      end else if (sel < 92) begin
        load_entry(8'($urandom_range(0, 255)), fresh_entry());
      end else if (sel < 96) begin
        send_item(make_item(CMD_UNUSED, 8'($urandom_range(0, 255))));
      end else begin
        // Run header abandoned by a new row.
        send_byte(RUN_TAG_MASK | 8'($urandom_range(0, 63)));
        start_row();
      end
    end
  endtask

  // Pixel sink: a random stall before each pixel, and a long hold when asked.
  initial begin : pixel_sink
    int stall;
    int holds_done;
    holds_done = 0;
    while (rst) @(posedge clk);
    forever begin
      if (holds_done != hold_requests) begin
        pixel_ready <= 1'b0;
        repeat (400) @(posedge clk);
        holds_done++;
      end
      stall = sink_quiet ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        pixel_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pixel_ready <= 1'b1;
      @(posedge clk);
      while (!pixel_valid) @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int w;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass at the reset width.
    load_entry(8'h00, 32'h0000_0000);
    load_entry(8'hFF, 32'hFFFF_FFFF);
    load_entry(8'h3F, 32'h8000_0000);
    load_entry(8'hC0, 32'h0056_3412);
    load_entry(8'h80, 32'h3CC3_5AA5);
    start_row();
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hC0);
    send_byte(8'h3F);
    send_byte(8'hC2);
    send_byte(8'h00);
    send_byte(8'hC1);
    send_byte(8'h3F);
    send_item('{command: CMD_UNUSED, data_byte: 8'hFF, entry_index: 8'hFF,
                entry_red: 8'hFF, entry_green: 8'hFF, entry_blue: 8'hFF,
                entry_flags: 8'hFF});

    // An empty row ignores all data.
    set_width(0);
    start_row();
    send_byte(8'h80);

    // One-pixel row: the run is clipped and later bytes are ignored.
    set_width(1);
    start_row();
    send_byte(8'hC5);
    send_byte(8'hFF);
    send_byte(8'h80);

    // Width lowered below the current position in the middle of a row.
    set_width(10);
    start_row();
    send_byte(8'h80);
    send_byte(8'h3F);
    send_byte(8'h00);
    set_width(2);
    send_byte(8'h80);
    start_row();
    send_byte(8'h80);

    // Row of long runs (width saturates) under a long output stall, with
    // the sender offering items back to back so the decoder stalls its input.
    set_width(8191);
    send_quiet = 1'b1;
    sink_quiet = 1'b1;
    start_row();
    hold_requests++;
    repeat (6) begin
      send_byte(8'hFF);
      send_byte(8'($urandom_range(0, 255)));
    end
    send_byte(8'h80);

    // Random rows under a range of widths and pacing.
    while (items_sent < 150) begin
      case ($urandom_range(0, 5))
        0:       w = 1;
        1:       w = 4096;
        2:       w = 8191;
        default: w = $urandom_range(2, 48);
      endcase
      set_width(w);
      send_quiet = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) random_row($urandom_range(4, 14));
    end

    drain();
    repeat (16) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Run limit.
  initial begin : watchdog
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pcxrle_pkg.sv
hw/rtl/pcxrle_palette_ram.sv
hw/rtl/pcxrle_decoder_core.sv
hw/rtl/pcx_rle_palette_decoder.sv
hw/rtl/pcxrle_checker.sv
sim/pcx_decode_checker.sv
sim/testbench.sv
